@@ design/frfa_pkg.sv @@
// Shared constants, types and control word for the first-fit row allocator.
// No dependencies; used by frfa_cell and first_fit_row_allocator_core.
`timescale 1ns / 1ps

package frfa_pkg;

   localparam int DATA_W     = 32;
   localparam int ROWS       = 256;
   localparam int LEVELS     = $clog2(ROWS);
   localparam int LEAVES     = 1 << LEVELS;
   localparam int CELL_DEPTH = LEAVES / 2;
   localparam int ADDR_W     = (LEVELS > 1) ? LEVELS - 1 : 1;
   localparam int NODE_W     = LEVELS;
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int ACT_W      = $clog2(ROWS + 1);
   localparam int ROW_IDX_W  = 8;
   localparam int RIU_W      = 9;
   localparam int CSR_IDX_W  = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_WIDTH   = 1'b0,
      CSR_ROWS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FILL,
      PH_SEEK,
      PH_MEND
   } phase_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_SEEK,
      ST_MEND,
      ST_REPLY
   } state_type;

   // control word broadcast from the sequencer to every cell
   typedef struct packed {
      phase_type          phase;
      logic [LVL_W-1:0]   step;
      logic               commit;
      logic [ADDR_W-1:0]  fill_addr;
      logic [DATA_W-1:0]  fill_value;
      logic [ACT_W-1:0]   active;
      logic [DATA_W-1:0]  want;
   } cell_ctl_type;

endpackage

@@ design/frfa_cell.sv @@
// One tree level of the allocator: holds the child pairs of that level's nodes.
// Depends on frfa_pkg; instantiated in a chain by first_fit_row_allocator_core.
`timescale 1ns / 1ps

module frfa_cell (
   input  logic                         clock,
   input  logic [frfa_pkg::LVL_W-1:0]   lvl,
   input  frfa_pkg::cell_ctl_type       ctl,
   input  logic [frfa_pkg::NODE_W-1:0]  seek_in,
   output logic [frfa_pkg::NODE_W-1:0]  seek_out,
   input  logic [frfa_pkg::DATA_W-1:0]  mend_in,
   output logic [frfa_pkg::DATA_W-1:0]  mend_out
);
   import frfa_pkg::*;

   // pair memory: [DATA_W-1:0] left child, upper half right child
   logic [2*DATA_W-1:0] mem [CELL_DEPTH];

   logic [DATA_W-1:0] left_ff, right_ff, mend_ff;
   logic [NODE_W-1:0] node_ff;

   logic              is_last, my_turn, go_right;
   logic [LVL_W-1:0]  sh;
   logic [LEVELS:0]   lo_first, hi_first;
   logic              lo_on, hi_on, fill_here;
   logic [DATA_W-1:0] new_half, new_left, new_right;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [2*DATA_W-1:0] wdata;

   assign is_last  = (lvl == LVL_W'(LEVELS - 1));
   assign my_turn  = (ctl.step == lvl);
   assign go_right = !(left_ff >= ctl.want);
   assign seek_out = NODE_W'({node_ff, go_right});
   assign mend_out = mend_ff;

   // refill: a child node is live if its first leaf lies below the active count
   always_comb begin
      sh        = LVL_W'(LEVELS - 1) - lvl;
      lo_first  = (LEVELS + 1)'({ctl.fill_addr, 1'b0}) << sh;
      hi_first  = (LEVELS + 1)'({ctl.fill_addr, 1'b1}) << sh;
      lo_on     = lo_first < (LEVELS + 1)'(ctl.active);
      hi_on     = hi_first < (LEVELS + 1)'(ctl.active);
      fill_here = ((ctl.fill_addr >> lvl) == '0);
   end

   // update: leaf level subtracts, upper levels take the new max from below
   always_comb begin
      if (is_last) begin
         new_half = (go_right ? right_ff : left_ff) - ctl.want;
      end else begin
         new_half = mend_in;
      end
      new_left  = go_right ? left_ff : new_half;
      new_right = go_right ? new_half : right_ff;
   end

   always_comb begin
      we    = 1'b0;
      waddr = ctl.fill_addr;
      wdata = {(hi_on ? ctl.fill_value : '0), (lo_on ? ctl.fill_value : '0)};
      case (ctl.phase)
         PH_FILL: begin
            we = fill_here;
         end
         PH_MEND: begin
            we    = my_turn && ctl.commit;
            waddr = node_ff[ADDR_W-1:0];
            wdata = {new_right, new_left};
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.phase == PH_SEEK && my_turn) begin
         {right_ff, left_ff} <= mem[seek_in[ADDR_W-1:0]];
         node_ff             <= seek_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.phase == PH_MEND && my_turn && ctl.commit) begin
         mend_ff <= (new_left > new_right) ? new_left : new_right;
      end
   end

endmodule

@@ design/first_fit_row_allocator_core.sv @@
// First-fit row allocator: sequencer, root and chain of tree-level cells.
// Depends on frfa_pkg and frfa_cell.
`timescale 1ns / 1ps

// Usage
//  - Input: raise start with req_item_width; the word is taken on a clock edge
//    where start is high and busy is low. busy stays high until the result
//    has gone out.
//  - Result: rsp_valid is high for exactly one cycle with rsp_placed and
//    rsp_row_index (0 when not placed). The receiver cannot stall; it must
//    take the word in that cycle.
//  - Timing: the word walks down the cell chain, one level per cycle through
//    each cell's registered pair memory, then back up (cut short if the leaf
//    lies outside the rows in use). When the root already shows no row fits,
//    the result comes in the next cycle. A new word is taken only after the
//    previous result has gone out.
//  - Config: csr_write_en with csr_index/csr_write_data, only while idle.
//    busy is also high in the cycle of a write, so no word is taken then.
//    Any write refills every row in a sweep with busy high.
//  - Reset: synchronous, active high. Registers go to row_width all ones
//    and rows_in_use 256, then the same refill sweep runs.

module first_fit_row_allocator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [frfa_pkg::DATA_W-1:0]          req_item_width,
   output logic                                 rsp_valid,
   output logic                                 rsp_placed,
   output logic [frfa_pkg::ROW_IDX_W-1:0]       rsp_row_index,
   input  logic                                 csr_write_en,
   input  logic [frfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [frfa_pkg::DATA_W-1:0]          csr_write_data
);
   import frfa_pkg::*;

   localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(CELL_DEPTH - 1);
   localparam logic [LVL_W-1:0]  STEP_LAST = LVL_W'(LEVELS - 1);

   state_type              state_ff, state_in;
   logic [LVL_W-1:0]       step_ff, step_in;
   logic [ADDR_W-1:0]      fill_addr_ff, fill_addr_in;
   logic [DATA_W-1:0]      want_ff, want_in;
   logic [DATA_W-1:0]      root_ff, root_in;
   logic                   placed_ff, placed_in;
   logic [ROW_IDX_W-1:0]   row_ff, row_in;
   logic [DATA_W-1:0]      row_width_ff, row_width_in;
   logic [RIU_W-1:0]       rows_in_use_ff, rows_in_use_in;

   logic [ACT_W-1:0]       active;
   logic                   accept, fits, row_ok;
   logic [NODE_W-1:0]      row;
   cell_ctl_type           ctl;

   // chain links between neighbouring cells
   logic [NODE_W-1:0]      seek_link [LEVELS+1];
   logic [DATA_W-1:0]      mend_link [LEVELS+1];

   assign active = (32'(rows_in_use_ff) > ROWS) ? ACT_W'(ROWS) : ACT_W'(rows_in_use_ff);
   assign accept = start && !busy;
   assign fits   = (root_ff >= req_item_width) && (active != '0);
   assign row    = seek_link[LEVELS];
   assign row_ok = (LEVELS + 1)'(row) < (LEVELS + 1)'(active);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (csr_write_en) begin
               state_in = ST_FILL;
            end else if (fill_addr_ff == FILL_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (csr_write_en) begin
               state_in = ST_FILL;
            end else if (start) begin
               state_in = fits ? ST_SEEK : ST_REPLY;
            end
         end
         ST_SEEK: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_MEND;
            end
         end
         ST_MEND: begin
            if (step_ff == STEP_LAST && !row_ok) begin
               state_in = ST_REPLY;
            end else if (step_ff == '0) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // outputs, cell control and datapath registers
   always_comb begin
      busy           = (state_ff != ST_IDLE) || csr_write_en;
      rsp_valid      = (state_ff == ST_REPLY);
      rsp_placed     = placed_ff;
      rsp_row_index  = row_ff;

      step_in        = step_ff;
      fill_addr_in   = fill_addr_ff;
      want_in        = want_ff;
      root_in        = root_ff;
      placed_in      = placed_ff;
      row_in         = row_ff;
      row_width_in   = row_width_ff;
      rows_in_use_in = rows_in_use_ff;

      ctl.phase      = PH_IDLE;
      ctl.step       = step_ff;
      ctl.commit     = (step_ff != STEP_LAST) || row_ok;
      ctl.fill_addr  = fill_addr_ff;
      ctl.fill_value = row_width_ff;
      ctl.active     = active;
      ctl.want       = want_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROW_WIDTH:   row_width_in   = csr_write_data;
            CSR_ROWS_IN_USE: rows_in_use_in = csr_write_data[RIU_W-1:0];
            default:         row_width_in   = row_width_ff;
         endcase
         fill_addr_in = '0;
      end

      unique case (state_ff)
         ST_FILL: begin
            ctl.phase = PH_FILL;
            root_in   = (active != '0) ? row_width_ff : '0;
            if (!csr_write_en) begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (accept && !csr_write_en) begin
               want_in   = req_item_width;
               step_in   = '0;
               placed_in = 1'b0;
               row_in    = '0;
            end
         end
         ST_SEEK: begin
            ctl.phase = PH_SEEK;
            if (step_ff != STEP_LAST) begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MEND: begin
            ctl.phase = PH_MEND;
            if (step_ff == STEP_LAST) begin
               placed_in = row_ok;
               row_in    = row_ok ? ROW_IDX_W'(row) : '0;
            end
            step_in = step_ff - 1'b1;
         end
         ST_REPLY: begin
            if (placed_ff) begin
               root_in = mend_link[0];
            end
         end
         default: begin
            ctl.phase = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_FILL;
         fill_addr_ff   <= '0;
         step_ff        <= '0;
         placed_ff      <= 1'b0;
         row_ff         <= '0;
         row_width_ff   <= '1;
         rows_in_use_ff <= RIU_W'(256);
      end else begin
         state_ff       <= state_in;
         fill_addr_ff   <= fill_addr_in;
         step_ff        <= step_in;
         placed_ff      <= placed_in;
         row_ff         <= row_in;
         row_width_ff   <= row_width_in;
         rows_in_use_ff <= rows_in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      root_ff <= root_in;
   end

   // the root's children sit in cell 0; the leaves in the last cell
   assign seek_link[0]      = '0;
   assign mend_link[LEVELS] = '0;

   for (genvar k = 0; k < LEVELS; k++) begin : g_cell
      frfa_cell u_cell (
         .clock    (clock),
         .lvl      (LVL_W'(k)),
         .ctl      (ctl),
         .seek_in  (seek_link[k]),
         .seek_out (seek_link[k+1]),
         .mend_in  (mend_link[k+1]),
         .mend_out (mend_link[k])
      );
   end

endmodule

@@ tb/sv/tb_first_fit_row_allocator_core.sv @@
// Self-checking testbench for first_fit_row_allocator_core: directed words, then
// random phases under many row settings, checked against a first-fit predictor.
// Depends on frfa_pkg and the design files only.
`timescale 1ns / 1ps

module tb_first_fit_row_allocator_core;

   import frfa_pkg::*;

   localparam int QUIET_LIMIT = 5000;         // cycles with no word moving anywhere
   localparam int DRAIN       = 2 * LEVELS + 4;
   localparam int PHASES      = 9;

   typedef struct packed {
      logic                 placed;
      logic [ROW_IDX_W-1:0] row;
   } placement_type;

   // Row-level model: one remaining capacity per row, first fit by linear scan.
   class alloc_scoreboard;
      logic [DATA_W-1:0] row_cap [ROWS];
      logic [DATA_W-1:0] fill_width;
      logic [RIU_W-1:0]  rows_reg;
      placement_type     pending_q[$];
      int                failures;

      function new();
         fill_width = '1;
         rows_reg   = 9'd256;
         failures   = 0;
         refill();
      endfunction

      function int active_rows();
         return (rows_reg > ROWS) ? ROWS : int'(rows_reg);
      endfunction

      function void refill();
         for (int i = 0; i < ROWS; i++)
            row_cap[i] = (i < active_rows()) ? fill_width : '0;
      endfunction

      function void write_register(csr_index_type idx, logic [DATA_W-1:0] data);
         case (idx)
            CSR_ROW_WIDTH:   fill_width = data;
            CSR_ROWS_IN_USE: rows_reg   = data[RIU_W-1:0];
            default: ;
         endcase
         refill();
      endfunction

      // Predict the placement for a word just taken and queue it.
      function void note_word(logic [DATA_W-1:0] w);
         placement_type p;
         bit            found;
         p     = '0;
         found = 1'b0;
         for (int r = 0; r < active_rows(); r++) begin
            if (!found && row_cap[r] >= w) begin
               found      = 1'b1;
               row_cap[r] = row_cap[r] - w;
               p.placed   = 1'b1;
               p.row      = r[ROW_IDX_W-1:0];
            end
         end
         pending_q.push_back(p);
      endfunction

      function void check_word(logic placed, logic [ROW_IDX_W-1:0] row);
         placement_type want;
         if (pending_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected result word placed=%0b row=%0d", $time, placed, row);
            return;
         end
         want = pending_q.pop_front();
         if (placed !== want.placed) begin
            failures++;
            $display("%0t: placed expected %0b actual %0b", $time, want.placed, placed);
         end
         if (row !== want.row) begin
            failures++;
            $display("%0t: row_index expected %0d actual %0d", $time, want.row, row);
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  start          = 1'b0;
   logic                  busy;
   logic [DATA_W-1:0]     req_item_width = '0;
   logic                  rsp_valid;
   logic                  rsp_placed;
   logic [ROW_IDX_W-1:0]  rsp_row_index;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [DATA_W-1:0]     csr_write_data = '0;

   int                    quiet_cycles   = 0;
   alloc_scoreboard       sb;

   // per-phase row settings; the width and row count of phase 5 are randomised at run time
   logic [DATA_W-1:0] phase_width [PHASES] = '{32'd16, 32'd1, 32'hFFFF_FFFF, 32'd100,
                                              32'd1000, 32'd0, 32'd40, 32'h8000_0000,
                                              32'd8};
   logic [DATA_W-1:0] phase_rows  [PHASES] = '{32'd256, 32'd256, 32'd256, 32'd1,
                                              32'd511, 32'd0, 32'd0, 32'd200,
                                              32'hFFFF_FF00};
   int                phase_count [PHASES] = '{400, 100, 150, 60, 150, 150, 20, 120, 100};

   always #5 clock = ~clock;

   first_fit_row_allocator_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item_width (req_item_width),
      .rsp_valid      (rsp_valid),
      .rsp_placed     (rsp_placed),
      .rsp_row_index  (rsp_row_index),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Result side: the block cannot be stalled, so every strobe is a word taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_word(rsp_placed, rsp_row_index);
   end

   // Watchdog: any word moving on any port clears the count.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 || csr_write_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // Offer one word and hold it until the block takes it; start stays high
   // across back-to-back words so it is never dropped and raised in one step.
   task automatic send_word(input logic [DATA_W-1:0] w, input int gap);
      start          <= 1'b1;
      req_item_width <= w;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      sb.note_word(w);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Register write, only once every placement is back and the block is idle.
   task automatic write_csr(input csr_index_type idx, input logic [DATA_W-1:0] data);
      start <= 1'b0;
      do
         @(posedge clock);
      while (busy !== 1'b0 || sb.outstanding() != 0);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      sb.write_register(idx, data);
   endtask

   // Mostly short gaps, some long ones; none at all in a steady phase.
   function automatic int pick_gap(bit steady);
      int k;
      k = $urandom_range(0, 99);
      if (steady || k < 50)
         return 0;
      if (k < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Widths sized against the current row width so that rows fill up and the
   // search walks deep; exact fits drain a row to zero.
   function automatic logic [DATA_W-1:0] pick_width();
      logic [DATA_W-1:0] rw;
      int                k;
      int                n;
      rw = sb.fill_width;
      n  = sb.active_rows();
      k  = $urandom_range(0, 99);
      if (k < 5)
         return '0;
      if (k < 15 || rw == 0)
         return $urandom();
      if (k < 25 && n > 0)
         return sb.row_cap[$urandom_range(0, n - 1)];
      if (k < 60)
         return $urandom_range(rw, rw - (rw >> 1));
      return $urandom_range(rw, 1);
   endfunction

   initial begin
      bit steady;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: full-width rows, all 256 rows in use; refill runs first.
      send_word(32'd0, 0);               // zero width lands in row 0, nothing taken
      send_word(32'd1, 0);
      send_word(32'hFFFF_FFFF, 0);       // row 0 now one short, goes to row 1
      send_word(32'hFFFF_FFFE, 1);       // exact fit empties row 0
      send_word(32'hFFFF_FFFF, 0);
      send_word(32'h8000_0000, 2);
      send_word(32'h7FFF_FFFF, 0);

      // single row in use
      write_csr(CSR_ROWS_IN_USE, 32'd1);
      send_word(32'hFFFF_FFFF, 0);
      send_word(32'd1, 0);               // nothing left anywhere
      send_word(32'd0, 0);

      // no rows in use: every word comes back unplaced, zero width too
      write_csr(CSR_ROWS_IN_USE, 32'd0);
      send_word(32'd0, 0);
      send_word(32'd1, 0);

      // too many rows is clamped; unit-width rows
      write_csr(CSR_ROWS_IN_USE, 32'd300);
      write_csr(CSR_ROW_WIDTH, 32'd1);
      send_word(32'd1, 0);
      send_word(32'd1, 0);
      send_word(32'd1, 0);
      send_word(32'd2, 0);

      // zero-capacity rows only take zero-width pieces
      write_csr(CSR_ROW_WIDTH, 32'd0);
      send_word(32'd0, 0);
      send_word(32'd1, 0);

      // high data bits on the row count are dropped
      write_csr(CSR_ROWS_IN_USE, 32'hFFFF_FFFF);
      write_csr(CSR_ROW_WIDTH, 32'd3);
      send_word(32'd3, 0);
      send_word(32'd3, 0);

      // Random phases, one refill per setting.
      phase_width[5] = $urandom_range(5000, 2);
      phase_rows[5]  = $urandom_range(256, 1);
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(CSR_ROW_WIDTH, phase_width[ph]);
         write_csr(CSR_ROWS_IN_USE, phase_rows[ph]);
         steady = ($urandom_range(0, 3) == 0);
         repeat (phase_count[ph])
            send_word(pick_width(), pick_gap(steady));
      end

      start <= 1'b0;
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
design/frfa_pkg.sv
design/frfa_cell.sv
design/first_fit_row_allocator_core.sv
tb/sv/tb_first_fit_row_allocator_core.sv
